/* rtl/sparse_feature_varint_encoder_assert.svh */
// Assertion macros for the sparse feature varint encoder.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef SPARSE_FEATURE_VARINT_ENCODER_ASSERT_SVH
`define SPARSE_FEATURE_VARINT_ENCODER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SFVE_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sfve assertion failed");
// next-cycle implication
`define SFVE_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sfve assertion failed");
`else
`define SFVE_ASSERT_NOW(lbl, pre, post)
`define SFVE_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* rtl/sfve_pkg.sv */
// Shared types and constants for the sparse feature varint encoder.
// No dependencies.
package sfve_pkg;

    localparam logic [31:0] FLOAT_PLUS_ONE  = 32'h3F80_0000;
    localparam logic [31:0] FLOAT_MINUS_ONE = 32'hBF80_0000;

    // value flag in the two low bits of the code
    localparam logic [1:0] FLAG_PLUS_ONE = 2'd0;
    localparam logic [1:0] FLAG_NEG_ONE  = 2'd1;
    localparam logic [1:0] FLAG_GENERAL  = 2'd2;

    localparam int CODE_BITS  = 34;
    localparam int DIGIT_BITS = 7;

    // serialiser status towards the top level
    typedef struct packed {
        logic       busy;   // a byte is on offer
        logic       last;   // offered byte is the final one of the feature
        logic [7:0] data;   // offered byte
    } ser_status_t;

endpackage

/* rtl/sfve_serialiser.sv */
// Byte serialiser: shifts the varint code out 7 bits a beat, then, for a general
// value, the float word 8 bits a beat. Depends on sfve_pkg.
module sfve_serialiser
    import sfve_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [CODE_BITS-1:0] load_code,
    input  logic [31:0]          load_value,
    input  logic                 load_general,
    input  logic                 step,
    output ser_status_t          status
);

    typedef enum logic {PH_VARINT, PH_FLOAT} phase_t;

    phase_t               phase_reg, phase_next;
    logic                 busy_reg, busy_next;
    logic [1:0]           fcnt_reg, fcnt_next;
    logic [CODE_BITS-1:0] code_reg, code_next;
    logic [31:0]          val_reg, val_next;
    logic                 general_reg, general_next;
    logic                 more;

    assign more = |code_reg[CODE_BITS-1:DIGIT_BITS];

    always_comb
    begin
        status.busy = busy_reg;
        if (phase_reg == PH_VARINT)
        begin
            status.data = {more, code_reg[DIGIT_BITS-1:0]};
            status.last = !more && !general_reg;
        end
        else
        begin
            status.data = val_reg[7:0];
            status.last = (fcnt_reg == 2'd3);
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        busy_next    = busy_reg;
        fcnt_next    = fcnt_reg;
        code_next    = code_reg;
        val_next     = val_reg;
        general_next = general_reg;
        if (step)
        begin
            case (phase_reg)
                PH_VARINT:
                begin
                    if (more)
                        code_next = {{DIGIT_BITS{1'b0}}, code_reg[CODE_BITS-1:DIGIT_BITS]};
                    else if (general_reg)
                    begin
                        phase_next = PH_FLOAT;
                        fcnt_next  = 2'd0;
                    end
                    else
                        busy_next = 1'b0;
                end
                PH_FLOAT:
                begin
                    val_next  = {8'd0, val_reg[31:8]};
                    fcnt_next = fcnt_reg + 2'd1;
                    if (fcnt_reg == 2'd3)
                        busy_next = 1'b0;
                end
                default:
                    busy_next = 1'b0;
            endcase
        end
        // a load may coincide with the final step of the previous feature
        if (load)
        begin
            phase_next   = PH_VARINT;
            busy_next    = 1'b1;
            code_next    = load_code;
            val_next     = load_value;
            general_next = load_general;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_VARINT;
            busy_reg  <= 1'b0;
            fcnt_reg  <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            fcnt_reg  <= fcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg    <= code_next;
        val_reg     <= val_next;
        general_reg <= general_next;
    end

endmodule

/* rtl/sparse_feature_varint_encoder.sv */
// Sparse feature varint encoder, top level. Depends on sfve_pkg, sfve_serialiser
// and sparse_feature_varint_encoder_assert.svh.
// Output: n bytes per feature, n = varint digits (1..5) plus 4 float bytes
// for a general value, so 1 to 9; the serialiser gives one byte a cycle while
// the output is free or emptied, each via the serialiser and output registers.
// Reset: asynchronous, active low; clears previous index, group byte count and
// all handshake state.
`include "sparse_feature_varint_encoder_assert.svh"
module sparse_feature_varint_encoder
    import sfve_pkg::*;
#(
    parameter int INDEX_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // feature_index [31:0], value_bits [63:32]
    input  logic        s_axis_tuser,  // group_start
    input  logic        s_axis_tlast,  // group_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // out_byte [7:0], group_byte_count [39:8]
    output logic        m_axis_tuser,  // item_last
    output logic        m_axis_tlast   // group_done
);

    // low INDEX_BITS bits of the index are kept
    localparam logic [32:0] IDX_ONE  = 33'd1 << INDEX_BITS;
    localparam logic [31:0] IDX_MASK = 32'(IDX_ONE - 33'd1);

    ser_status_t ser;

    logic        load;
    logic        step;
    logic [31:0] index;
    logic [31:0] base;
    logic [31:0] diff;
    logic [31:0] zig;
    logic [1:0]  flag;
    logic        general;
    logic [31:0] bytes_inc;

    logic [31:0] prev_index_reg, prev_index_next;
    logic [31:0] group_bytes_reg, group_bytes_next;
    logic        end_reg, end_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg, m_byte_next;
    logic [31:0] m_count_reg, m_count_next;
    logic        m_item_last_reg, m_item_last_next;
    logic        m_group_done_reg, m_group_done_next;

    sfve_serialiser u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .load_code    ({zig, flag}),
        .load_value   (s_axis_tdata[63:32]),
        .load_general (general),
        .step         (step),
        .status       (ser)
    );

    // one byte moves to the output register when it is free or being emptied
    assign step          = ser.busy && (!m_valid_reg || m_axis_tready);
    // next feature may load on the beat its predecessor's final byte leaves
    assign s_axis_tready = !ser.busy || (step && ser.last);
    assign load          = s_axis_tvalid && s_axis_tready;

    // delta against previous index (zero on a group start), then zigzag
    assign index = s_axis_tdata[31:0] & IDX_MASK;
    assign base  = s_axis_tuser ? 32'd0 : prev_index_reg;
    assign diff  = index - base;
    assign zig   = {diff[30:0], 1'b0} ^ {32{diff[31]}};

    always_comb
    begin
        if (s_axis_tdata[63:32] == FLOAT_MINUS_ONE)
            flag = FLAG_NEG_ONE;
        else if (s_axis_tdata[63:32] == FLOAT_PLUS_ONE)
            flag = FLAG_PLUS_ONE;
        else
            flag = FLAG_GENERAL;
    end
    assign general = (flag == FLAG_GENERAL);

    // saturating byte count
    assign bytes_inc = (group_bytes_reg == 32'hFFFF_FFFF) ? group_bytes_reg
                                                          : group_bytes_reg + 32'd1;

    always_comb
    begin
        prev_index_next   = prev_index_reg;
        group_bytes_next  = group_bytes_reg;
        end_next          = end_reg;
        m_valid_next      = m_valid_reg;
        m_byte_next       = m_byte_reg;
        m_count_next      = m_count_reg;
        m_item_last_next  = m_item_last_reg;
        m_group_done_next = m_group_done_reg;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        if (step)
        begin
            m_valid_next      = 1'b1;
            m_byte_next       = ser.data;
            m_count_next      = bytes_inc;
            m_item_last_next  = ser.last;
            m_group_done_next = ser.last && end_reg;
            group_bytes_next  = bytes_inc;
        end

        // group start clears the count after the previous feature's last beat
        if (load)
        begin
            prev_index_next = index;
            end_next        = s_axis_tlast;
            if (s_axis_tuser)
                group_bytes_next = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_index_reg  <= 32'd0;
            group_bytes_reg <= 32'd0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            prev_index_reg  <= prev_index_next;
            group_bytes_reg <= group_bytes_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg          <= end_next;
        m_byte_reg       <= m_byte_next;
        m_count_reg      <= m_count_next;
        m_item_last_reg  <= m_item_last_next;
        m_group_done_reg <= m_group_done_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_count_reg, m_byte_reg};
    assign m_axis_tuser  = m_item_last_reg;
    assign m_axis_tlast  = m_group_done_reg;

    // group done only ever on a feature's final byte
    `SFVE_ASSERT_NOW(a_done_on_last, m_valid_reg && m_group_done_reg, m_item_last_reg)
    // a non-final byte at the output means the serialiser still holds the rest
    `SFVE_ASSERT_NOW(a_rest_pending, m_valid_reg && !m_item_last_reg, ser.busy)
    // byte count follows each beat into the output register unless cleared
    `SFVE_ASSERT_NEXT(a_count_step, step && !load, group_bytes_reg == $past(bytes_inc))
    `SFVE_ASSERT_NEXT(a_count_out, step, m_count_reg == $past(bytes_inc))

endmodule
